// File: hdl/q8db_pkg.sv
// Package for the Q8_0 block dequantizer: sizes and the half-to-single widening function.
// No dependencies.
`timescale 1ns / 1ps
package q8db_pkg;
   localparam int VALUES_PER_BLOCK = 32;
   localparam int MAX_ROW_BLOCKS = 4096;
   localparam int BYTES_PER_BLOCK = VALUES_PER_BLOCK + 2;

   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0] ex;
      logic [9:0] man;
      logic [7:0] e;
      logic [31:0] r;
      int lz;
      ex = h[14:10];
      man = h[9:0];
      lz = 0;
      for (int i = 0; i < 10; i++) begin
         if (man[9 - i] && lz == 0) lz = i + 1;
      end
      r = {h[15], 31'd0};
      if (ex == 5'd0) begin
         if (man != 10'd0) begin
            e = 8'd113 - 8'(lz);
            r = {h[15], e, 23'(10'(man << lz)) << 13};
         end
      end else if (ex == 5'd31) begin
         r = {h[15], 8'hff, man, 13'd0};
      end else begin
         r = {h[15], 8'({3'd0, ex} + 8'd112), man, 13'd0};
      end
      return r;
   endfunction
endpackage

// File: hdl/q8_0_block_dequantizer.sv
// Q8_0 block dequantizer top level: input register, scale register, product and result register.
// Depends on q8db_pkg.
// An accepted quant byte passes through the input register and then the result register to its result beat on rsp.
// Throughput: one byte per cycle while rsp is not stalled; the two scale bytes of a block give no result.
// Reset is synchronous and active high; it clears position, counters and valid flags.
`timescale 1ns / 1ps
module q8_0_block_dequantizer #(
   parameter int MaxRowBlocks = q8db_pkg::MAX_ROW_BLOCKS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // value_bits
   output logic [1:0]  rsp_tuser,   // [1] row_end, [0] block_end
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);
   localparam int CW = (MaxRowBlocks > 1) ? $clog2(MaxRowBlocks) : 1;
   localparam int LW = $clog2(MaxRowBlocks + 1);

   logic [12:0] row_blocks_ff;
   logic [5:0] pos_ff;
   logic [7:0] lo_ff;
   logic [31:0] scale_ff;
   logic [CW-1:0] blk_ff;
   logic s1_v_ff, s1_be_ff, s1_re_ff;
   logic [7:0] s1_q_ff;
   logic [31:0] s1_s_ff;
   logic o_v_ff;
   logic [31:0] o_d_ff;
   logic [1:0] o_u_ff;

   logic adv, take;
   logic [LW:0] limit;
   logic last, rend;
   logic [31:0] val_in;

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata = o_d_ff;
   assign rsp_tuser = o_u_ff;
   assign adv = !o_v_ff || rsp_tready;
   assign req_tready = adv || !s1_v_ff;
   assign take = req_tvalid && req_tready;

   always_comb begin
      if (row_blocks_ff == 13'd0) limit = (LW+1)'(1);
      else if (32'(row_blocks_ff) > MaxRowBlocks) limit = (LW+1)'(MaxRowBlocks);
      else limit = (LW+1)'(row_blocks_ff);
      last = (pos_ff == 6'(q8db_pkg::BYTES_PER_BLOCK - 1));
      rend = ((LW+1)'(blk_ff) + (LW+1)'(1)) >= limit;
   end

   always_comb begin
      logic qn;
      logic [7:0] qm;
      logic [18:0] prod;
      logic [31:0] rs;
      int p;
      qn = s1_q_ff[7];
      qm = qn ? 8'(-s1_q_ff) : s1_q_ff;
      rs = {s1_s_ff[31] ^ qn, 31'd0};
      prod = {8'd0, 1'b1, s1_s_ff[22:13]} * {11'd0, qm};
      p = 0;
      for (int i = 1; i < 19; i++) if (prod[i]) p = i;
      if (s1_s_ff[30:23] == 8'hff) begin
         if (s1_s_ff[22:0] != 23'd0) val_in = s1_s_ff | 32'h0040_0000;
         else if (qm == 8'd0) val_in = 32'hffc0_0000;
         else val_in = rs | 32'h7f80_0000;
      end else if (s1_s_ff[30:0] == 31'd0 || qm == 8'd0) begin
         val_in = rs;
      end else begin
         val_in = rs | {1'b0, 8'(s1_s_ff[30:23] - 8'd10 + 8'(p)),
                        23'({4'd0, prod} << (23 - p))};
      end
   end

   always_ff @(posedge clock) begin
      if (csr_wr_en) row_blocks_ff <= csr_wr_data;
      if (take) begin
         if (pos_ff == 6'd0) lo_ff <= req_tdata;
         if (pos_ff == 6'd1) scale_ff <= q8db_pkg::half_to_single({req_tdata, lo_ff});
         s1_q_ff <= req_tdata;
         s1_s_ff <= scale_ff;
         s1_be_ff <= last;
         s1_re_ff <= last && rend;
      end
      if (adv && s1_v_ff) begin
         o_d_ff <= val_in;
         o_u_ff <= {s1_re_ff, s1_be_ff};
      end
      if (reset) begin
         row_blocks_ff <= 13'd1;
         pos_ff <= '0;
         blk_ff <= '0;
         s1_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (adv) o_v_ff <= s1_v_ff;
         if (take) begin
            s1_v_ff <= (pos_ff > 6'd1);
            if (last) begin
               pos_ff <= '0;
               blk_ff <= rend ? '0 : blk_ff + CW'(1);
            end else begin
               pos_ff <= pos_ff + 6'd1;
            end
         end else if (adv) begin
            s1_v_ff <= 1'b0;
         end
      end
   end
endmodule

// File: hdl/q8db_checker.sv
// Port checker for the Q8_0 block dequantizer, bound to the top level.
// Depends on q8_0_block_dequantizer.
`timescale 1ns / 1ps
module q8db_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");
   a_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("row end without block end");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");
endmodule

bind q8_0_block_dequantizer q8db_checker u_chk (.*);

// File: tb/q8_0_block_dequantizer_tb.sv
// Self-checking testbench for q8_0_block_dequantizer: walks a table of directed blocks and then
// random rows under changing row lengths and idle patterns, checking each beat against a predictor.
// Depends on q8db_pkg and the q8_0_block_dequantizer RTL.
`timescale 1ns / 1ps
module q8_0_block_dequantizer_tb;

   typedef struct packed {
      logic [31:0] value;
      logic        block_end;
      logic        row_end;
   } dq_value_type;

   typedef struct {
      logic [7:0]  data;
      int          count;
      logic        typed;
      logic [31:0] value;
   } byte_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   dq_value_type pending_values[$];
   int          mismatches = 0;
   int          beats_seen = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        recv_hold;
   logic        stall_go;

   logic [12:0] row_len_reg;
   logic [5:0]  byte_pos;
   logic [7:0]  scale_lo;
   logic [31:0] scale_sp;
   logic [11:0] block_idx;
   logic [31:0] last_value;

   q8_0_block_dequantizer u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      recv_hold = 1'b0;
      wait (stall_go === 1'b1);
      @(posedge clock);
      recv_hold <= 1'b1;
      repeat (300) @(posedge clock);
      recv_hold <= 1'b0;
   end

   function automatic logic [31:0] widen_half(input logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] man;
      int          e;
      sgn = {h[15], 31'd0};
      ex = h[14:10];
      man = {1'b0, h[9:0]};
      if (ex == 5'd0) begin
         if (man == 11'd0) return sgn;
         e = 113;
         while (!man[10]) begin
            man = man << 1;
            e--;
         end
         return sgn | (32'(e) << 23) | (32'(man[9:0]) << 13);
      end
      if (ex == 5'd31) return sgn | 32'h7f80_0000 | (32'(man[9:0]) << 13);
      return sgn | (32'(ex + 112) << 23) | (32'(man[9:0]) << 13);
   endfunction

   function automatic logic [31:0] scale_quant(input logic [31:0] s, input logic [7:0] q);
      logic [7:0]  sexp;
      logic [22:0] sman;
      logic [7:0]  qmag;
      logic [31:0] rsign;
      logic [31:0] prod;
      int          e;
      int          p;
      sexp = s[30:23];
      sman = s[22:0];
      qmag = q[7] ? 8'(-q) : q;
      rsign = {s[31] ^ q[7], 31'd0};
      if (q == 8'h80) qmag = 8'd128;
      if (sexp == 8'hff) begin
         if (sman != 0) return s | 32'h0040_0000;
         if (qmag == 0) return 32'hffc0_0000;
         return rsign | 32'h7f80_0000;
      end
      if ((sexp == 0 && sman == 0) || qmag == 0) return rsign;
      prod = 32'({1'b1, sman[22:13]}) * 32'(qmag);
      p = 0;
      while (p < 31 && (prod >> (p + 1)) != 0) p++;
      e = int'(sexp) - 137 + p + 127;
      if (e < 1) e = 1;
      if (e > 254) e = 254;
      return rsign | (32'(e) << 23) | ((prod << (23 - p)) & 32'h007f_ffff);
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      dq_value_type v;
      int          lim;
      if (byte_pos == 6'd0) begin
         scale_lo = b;
         byte_pos = 6'd1;
         return;
      end
      if (byte_pos == 6'd1) begin
         scale_sp = widen_half({b, scale_lo});
         byte_pos = 6'd2;
         return;
      end
      v.value = scale_quant(scale_sp, b);
      v.block_end = 1'b0;
      v.row_end = 1'b0;
      if (byte_pos >= q8db_pkg::BYTES_PER_BLOCK - 1) begin
         v.block_end = 1'b1;
         byte_pos = 6'd0;
         lim = (row_len_reg == 0) ? 1 : int'(row_len_reg);
         if (lim > q8db_pkg::MAX_ROW_BLOCKS) lim = q8db_pkg::MAX_ROW_BLOCKS;
         if (int'(block_idx) + 1 >= lim) begin
            v.row_end = 1'b1;
            block_idx = 12'd0;
         end else begin
            block_idx = block_idx + 12'd1;
         end
      end else begin
         byte_pos = byte_pos + 6'd1;
      end
      last_value = v.value;
      pending_values.insert(pending_values.size(), v);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      bytes_sent++;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_and_write(input logic [12:0] len);
      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      row_len_reg = len;
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_block();
      logic [15:0] h;
      case ($urandom_range(9))
         0: h = {1'($urandom_range(1)), 5'd31, 10'd0};
         1: h = {1'($urandom_range(1)), 5'd31, 10'($urandom_range(1, 1023))};
         2: h = {1'($urandom_range(1)), 15'd0};
         3: h = {1'($urandom_range(1)), 5'd0, 10'($urandom_range(1, 1023))};
         default: h = 16'($urandom);
      endcase
      send_byte(h[7:0]);
      send_byte(h[15:8]);
      for (int i = 0; i < q8db_pkg::VALUES_PER_BLOCK; i++) begin
         send_byte(($urandom_range(7) == 0) ? 8'h00 : 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         beats_seen++;
         if (pending_values.size() == 0) begin
            $error("unexpected beat: value_bits %h", rsp_tdata);
            mismatches++;
         end else begin
            dq_value_type e;
            e = pending_values.pop_front();
            if (rsp_tdata !== e.value) begin
               $error("value_bits: expected %h, got %h", e.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser[0] !== e.block_end) begin
               $error("block_end: expected %b, got %b", e.block_end, rsp_tuser[0]);
               mismatches++;
            end
            if (rsp_tuser[1] !== e.row_end) begin
               $error("row_end: expected %b, got %b", e.row_end, rsp_tuser[1]);
               mismatches++;
            end
         end
      end
      if (recv_hold === 1'b1) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   byte_row_type directed[] = '{
      '{8'h00, 1, 1'b0, 32'h0}, '{8'h3c, 1, 1'b0, 32'h0},
      '{8'h00, 1, 1'b1, 32'h0000_0000}, '{8'h7f, 1, 1'b1, 32'h42fe_0000},
      '{8'h80, 1, 1'b1, 32'hc300_0000}, '{8'hff, 1, 1'b1, 32'hbf80_0000},
      '{8'h01, 28, 1'b1, 32'h3f80_0000},
      '{8'h00, 1, 1'b0, 32'h0}, '{8'h7c, 1, 1'b0, 32'h0},
      '{8'h00, 1, 1'b1, 32'hffc0_0000}, '{8'h01, 1, 1'b1, 32'h7f80_0000},
      '{8'h80, 1, 1'b1, 32'hff80_0000}, '{8'h05, 29, 1'b1, 32'h7f80_0000},
      '{8'h01, 1, 1'b0, 32'h0}, '{8'h7d, 1, 1'b0, 32'h0},
      '{8'h00, 32, 1'b1, 32'h7fe0_2000},
      '{8'h01, 1, 1'b0, 32'h0}, '{8'h00, 1, 1'b0, 32'h0},
      '{8'h01, 1, 1'b1, 32'h3380_0000}, '{8'hff, 1, 1'b1, 32'hb380_0000},
      '{8'h00, 30, 1'b1, 32'h0000_0000},
      '{8'h00, 1, 1'b0, 32'h0}, '{8'h80, 1, 1'b0, 32'h0},
      '{8'h01, 31, 1'b1, 32'h8000_0000}, '{8'hff, 1, 1'b1, 32'h0000_0000}
   };

   logic [12:0] row_lengths[] = '{13'd2, 13'd0, 13'd3, 13'd4096, 13'd8191, 13'd5, 13'd1, 13'd7};

   initial begin
      int ph;
      reset = 1'b1;
      stall_go = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = 8'h00;
      csr_wr_en = 1'b0;
      csr_wr_data = 13'd0;
      row_len_reg = 13'd1;
      byte_pos = 6'd0;
      scale_lo = 8'd0;
      scale_sp = 32'd0;
      block_idx = 12'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[r]) begin
         for (int k = 0; k < directed[r].count; k++) begin
            send_byte(directed[r].data);
            if (directed[r].typed && last_value !== directed[r].value) begin
               $error("value_bits: expected %h, got %h", directed[r].value, last_value);
               mismatches++;
            end
         end
      end

      for (ph = 0; ph < 3 * row_lengths.size(); ph++) begin
         drain_and_write((ph == 3 * row_lengths.size() - 1) ?
                         13'($urandom_range(1, 8)) : row_lengths[ph % row_lengths.size()]);
         case (ph % 3)
            0: begin send_idle_pct = 23; recv_idle_pct = 55; end
            1: begin send_idle_pct = 55; recv_idle_pct = 23; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (ph == 4) stall_go = 1'b1;
         repeat (2) send_block();
         if ($urandom_range(1)) send_byte(8'($urandom));
      end

      req_tvalid <= 1'b0;
      while (pending_values.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (pending_values.size() != 0) mismatches++;
      $display("Sent %0d bytes and checked %0d value beats over %0d row lengths.",
               bytes_sent, beats_seen, row_lengths.size());
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
